// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files of the keyed table block
// each macro expects clk and rst_n in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define AST_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition implies a second one at the same edge
`define AST_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition implies a second one at the next edge
`define AST_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/core/ktts_pkg.sv
// shared types and defaults for the keyed table with top-two selection
// no dependencies; imported by the compare unit and the top level
`default_nettype none

package ktts_pkg;

    // default sizing of the table
    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_BYTES_DEF = 8;

    // request codes
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_EDIT   = 3'd1,
        OP_DELETE = 3'd2,
        OP_MIN    = 3'd3,
        OP_MAX    = 3'd4,
        OP_SMIN   = 3'd5,
        OP_SMAX   = 3'd6,
        OP_READ   = 3'd7
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_DUP       = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_FULL      = 3'd3,
        STS_FEW       = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    // flags from the shared compare unit
    typedef struct packed {
        logic key_eq;
        logic beats;
    } cmp_res_t;

endpackage

`default_nettype wire

// File: rtl/core/ktts_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module ktts_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/ktts_cmp.sv
// shared compare unit: key equality and signed value ordering
// depends on ktts_pkg for the result struct
`default_nettype none

module ktts_cmp
    import ktts_pkg::*;
#(
    parameter int KEY_W = 64
) (
    input  wire logic [KEY_W-1:0] a_key,
    input  wire logic [KEY_W-1:0] b_key,
    input  wire logic [31:0]      a_val,
    input  wire logic [31:0]      b_val,
    input  wire logic             want_max,
    output cmp_res_t              res
);

    // a beats b when strictly larger (max) or strictly smaller (min)
    always_comb
    begin
        res.key_eq = (a_key == b_key);
        res.beats  = want_max ? ($signed(a_val) > $signed(b_val))
                              : ($signed(a_val) < $signed(b_val));
    end

endmodule

`default_nettype wire

// File: rtl/core/keyed_table_top_two_select_core.sv
// top level of the keyed record table with top-two selection
// depends on ktts_pkg, ktts_ram, ktts_cmp and assert_macros.svh
//
// usage:
//   requests enter on in_valid/in_ready with op, record_key, new_value and
//   position; one result per request leaves on out_valid/out_ready with
//   status, found_position, found_key, found_value and record_count.
//   records live in one ram of CAPACITY entries that is walked one entry a
//   cycle through its single registered read port; the shared compare unit
//   checks one entry per cycle.
//   a delete moves every record behind the removed one down one place.
//   requests that fail the record count checks go straight to the finish
//   step without walking the table.
//   in_ready is high only while the sequencer is idle, one request at a time.
//   the result sits in an output register: a new request is taken while it
//   waits, and a stalled receiver holds the next result in the finish step.
//   reset empties the table (record count zero) and drops any pending result;
//   ram contents need no clearing since only held entries are ever read.
`default_nettype none

`include "assert_macros.svh"

module keyed_table_top_two_select_core
    import ktts_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         op,
    input  wire logic [63:0]        record_key,
    input  wire logic signed [31:0] new_value,
    input  wire logic [3:0]         position,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              status,
    output logic [3:0]              found_position,
    output logic [63:0]             found_key,
    output logic signed [31:0]      found_value,
    output logic [4:0]              record_count
);

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PW     = (CNT_W > 4) ? CNT_W : 4;
    localparam int DATA_W = KEY_W + 32;

    // sequencer and scan control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             dv_reg, dv_next;
    logic             hit_reg, hit_next;
    logic             have_reg, have_next;
    logic             pass2_reg, pass2_next;
    logic             out_valid_reg, out_valid_next;

    // request and selection payload
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [31:0]      val_reg, val_next;
    logic [3:0]       pos_reg, pos_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] first_idx_reg, first_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic [31:0]      best_val_reg, best_val_next;

    // result register
    status_t          out_status_reg, out_status_next;
    logic [3:0]       out_pos_reg, out_pos_next;
    logic [63:0]      out_key_reg, out_key_next;
    logic [31:0]      out_val_reg, out_val_next;
    logic [4:0]       out_count_reg, out_count_next;

    // ram port signals
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [31:0]       rd_val;

    // decoded conditions
    op_t              op_in;
    logic             accept;
    logic             out_free;
    logic             is_find;
    logic             is_second;
    logic             want_max;
    logic             scan_more;
    logic             issue;
    logic             scan_done;
    logic             candidate;
    logic             sel_err_in;
    logic [PW-1:0]    pos_in_w;
    logic [PW-1:0]    pos_w;
    logic [PW-1:0]    count_w;
    logic [IDX_W-1:0] pos_idx;
    cmp_res_t         cmp_res;

    // finish step result fields
    status_t          f_status;
    logic             f_give;
    logic [IDX_W-1:0] f_idx;
    logic [KEY_W-1:0] f_key;
    logic [31:0]      f_val;

    // record store
    ktts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[DATA_W-1:32];
    assign rd_val = ram_rdata[31:0];

    // shared compare unit: read entry against request key and current best
    ktts_cmp #(
        .KEY_W (KEY_W)
    ) u_cmp (
        .a_key    (rd_key),
        .b_key    (key_reg),
        .a_val    (rd_val),
        .b_val    (best_val_reg),
        .want_max (want_max),
        .res      (cmp_res)
    );

    // handshake and decode
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign op_in     = op_t'(op);
    assign is_find   = (op_reg == OP_INSERT) || (op_reg == OP_EDIT) || (op_reg == OP_DELETE);
    assign is_second = (op_reg == OP_SMIN) || (op_reg == OP_SMAX);
    assign want_max  = (op_reg == OP_MAX) || (op_reg == OP_SMAX);
    assign scan_more = (idx_reg < count_reg);
    assign pos_in_w  = PW'(position);
    assign pos_w     = PW'(pos_reg);
    assign count_w   = PW'(count_reg);
    assign pos_idx   = pos_w[IDX_W-1:0];
    assign candidate = !(pass2_reg && (cmp_idx_reg == first_idx_reg));

    // entry reads continue until the table end, or the key is hit on a lookup
    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            issue = scan_more && !(is_find && hit_reg);
        end
        else if (state_reg == S_SHIFT)
        begin
            issue = scan_more;
        end
        else
        begin
            issue = 1'b0;
        end
    end

    assign scan_done = !issue && !dv_reg;

    // record count checks made when the request arrives
    always_comb
    begin
        unique case (op_in)
            OP_MIN, OP_MAX:   sel_err_in = (count_reg == '0);
            OP_SMIN, OP_SMAX: sel_err_in = (count_reg < CNT_W'(2));
            OP_READ:          sel_err_in = (pos_in_w >= count_w);
            default:          sel_err_in = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sel_err_in)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (op_in == OP_READ)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (is_second && !pass2_reg)
                    begin
                        state_next = S_SCAN;
                    end
                    else if ((op_reg == OP_DELETE) && hit_reg)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SHIFT:
            begin
                if (scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result fields of the finish step
    always_comb
    begin
        f_status   = STS_OK;
        f_give     = 1'b0;
        f_idx      = best_idx_reg;
        f_key      = best_key_reg;
        f_val      = best_val_reg;
        count_next = count_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (hit_reg)
                begin
                    f_status = STS_DUP;
                    f_give   = 1'b1;
                end
                else if (count_reg >= CNT_W'(CAPACITY))
                begin
                    f_status = STS_FULL;
                end
                else
                begin
                    f_give     = 1'b1;
                    f_idx      = count_reg[IDX_W-1:0];
                    f_key      = key_reg;
                    f_val      = val_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_EDIT:
            begin
                if (hit_reg)
                begin
                    f_give = 1'b1;
                    f_val  = val_reg;
                end
                else
                begin
                    f_status = STS_NOT_FOUND;
                end
            end
            OP_DELETE:
            begin
                if (hit_reg)
                begin
                    f_give     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    f_status = STS_NOT_FOUND;
                end
            end
            OP_MIN, OP_MAX:
            begin
                if (count_reg == '0)
                begin
                    f_status = STS_FEW;
                end
                else
                begin
                    f_give = 1'b1;
                end
            end
            OP_SMIN, OP_SMAX:
            begin
                if (count_reg < CNT_W'(2))
                begin
                    f_status = STS_FEW;
                end
                else
                begin
                    f_give = 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_w >= count_w)
                begin
                    f_status = STS_FEW;
                end
                else
                begin
                    f_give = 1'b1;
                end
            end
        endcase
        if (!((state_reg == S_FINISH) && out_free))
        begin
            count_next = count_reg;
        end
    end

    // datapath, ram control and result register next values
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        dv_next         = 1'b0;
        hit_next        = hit_reg;
        have_next       = have_reg;
        pass2_next      = pass2_reg;
        cmp_idx_next    = idx_reg[IDX_W-1:0];
        first_idx_next  = first_idx_reg;
        best_idx_next   = best_idx_reg;
        best_key_next   = best_key_reg;
        best_val_next   = best_val_reg;
        ram_we          = 1'b0;
        ram_waddr       = cmp_idx_reg - IDX_W'(1);
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[IDX_W-1:0];
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_key_next    = out_key_reg;
        out_val_next    = out_val_reg;
        out_count_next  = out_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // latch the request and arm the scan
                if (accept)
                begin
                    op_next    = op_in;
                    key_next   = record_key[KEY_W-1:0];
                    val_next   = new_value;
                    pos_next   = position;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    have_next  = 1'b0;
                    pass2_next = 1'b0;
                end
            end
            S_READ:
            begin
                // single read at the asked position, no further entries
                ram_raddr    = pos_idx;
                dv_next      = 1'b1;
                cmp_idx_next = pos_idx;
                idx_next     = count_reg;
            end
            S_SCAN:
            begin
                dv_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                // compare the entry read in the previous cycle
                if (dv_reg)
                begin
                    if (is_find)
                    begin
                        if (cmp_res.key_eq && !hit_reg)
                        begin
                            hit_next      = 1'b1;
                            best_idx_next = cmp_idx_reg;
                            best_key_next = rd_key;
                            best_val_next = rd_val;
                        end
                    end
                    else if (candidate && (!have_reg || cmp_res.beats))
                    begin
                        have_next     = 1'b1;
                        best_idx_next = cmp_idx_reg;
                        best_key_next = rd_key;
                        best_val_next = rd_val;
                    end
                end
                // end of a pass: start the second pass or the gap close
                if (scan_done)
                begin
                    if (is_second && !pass2_reg)
                    begin
                        pass2_next     = 1'b1;
                        first_idx_next = best_idx_reg;
                        have_next      = 1'b0;
                        idx_next       = '0;
                    end
                    else if ((op_reg == OP_DELETE) && hit_reg)
                    begin
                        idx_next = CNT_W'(best_idx_reg) + CNT_W'(1);
                    end
                end
            end
            S_SHIFT:
            begin
                // read entry j, write it back at j-1 in the following cycle
                dv_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (dv_reg)
                begin
                    ram_we = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    // table writes for insert and edit
                    if ((op_reg == OP_INSERT) && f_give && !hit_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = count_reg[IDX_W-1:0];
                        ram_wdata = {key_reg, val_reg};
                    end
                    else if ((op_reg == OP_EDIT) && hit_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = best_idx_reg;
                        ram_wdata = {best_key_reg, val_reg};
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = f_status;
                    out_pos_next    = f_give ? 4'(f_idx) : 4'd0;
                    out_key_next    = f_give ? 64'(f_key) : 64'd0;
                    out_val_next    = f_give ? f_val : 32'd0;
                    out_count_next  = 5'(count_next);
                end
            end
            default:
            begin
                dv_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            dv_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            have_reg      <= 1'b0;
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_INSERT;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            dv_reg        <= dv_next;
            hit_reg       <= hit_next;
            have_reg      <= have_next;
            pass2_reg     <= pass2_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        cmp_idx_reg    <= cmp_idx_next;
        first_idx_reg  <= first_idx_next;
        best_idx_reg   <= best_idx_next;
        best_key_reg   <= best_key_next;
        best_val_reg   <= best_val_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_key_reg    <= out_key_next;
        out_val_reg    <= out_val_next;
        out_count_reg  <= out_count_next;
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign found_position = out_pos_reg;
    assign found_key      = out_key_reg;
    assign found_value    = out_val_reg;
    assign record_count   = out_count_reg;

    // checks
    `AST_HOLDS(a_count_range, count_reg <= CNT_W'(CAPACITY), "record count beyond capacity")
    `AST_IMPLIES(a_we_state, ram_we, (state_reg == S_SHIFT) || (state_reg == S_FINISH),
        "ram write outside shift or finish")
    `AST_NEXT(a_count_stable, state_reg != S_FINISH, $stable(count_reg),
        "record count moved outside finish")
    `AST_IMPLIES(a_shift_hit, state_reg == S_SHIFT, hit_reg && (op_reg == OP_DELETE),
        "gap close without a deleted record")

endmodule

`default_nettype wire
